/* hw/rtl/morse_key_decoder_top_macros.svh */
`ifndef MORSE_KEY_DECODER_TOP_MACROS_SVH
`define MORSE_KEY_DECODER_TOP_MACROS_SVH

// Same-cycle implication, checked on clk, off during reset.
`define MKD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on clk, off during reset.
`define MKD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* hw/rtl/mkd_pkg.sv */
`timescale 1ns / 1ps
package mkd_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int CFG_W          = 16;
	localparam int CFG_IDX_W      = 2;
	localparam int CHAR_W         = 7;
	localparam int SYM_W          = 5;
	localparam int SYM_CNT_W      = 3;
	localparam int EVQ_DEPTH      = 4;
	localparam int EVQ_AW         = 2;

	localparam logic [SYM_CNT_W-1:0] MAX_SYMBOLS = 3'd5;

	localparam logic [CFG_W-1:0] DOT_MIN_RST  = 16'd40;
	localparam logic [CFG_W-1:0] DASH_MIN_RST = 16'd220;
	localparam logic [CFG_W-1:0] GAP_LEN_RST  = 16'd400;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_DOT_MIN  = 2'd0,
		CFG_DASH_MIN = 2'd1,
		CFG_GAP_LEN  = 2'd2
	} cfg_idx_t;

	// Work handed from the front to the back.
	typedef enum logic [1:0] {
		EV_DOT  = 2'd0,
		EV_DASH = 2'd1,
		EV_GAP  = 2'd2
	} ev_kind_t;

	typedef struct packed {
		logic     valid;
		ev_kind_t kind;
	} ev_t;

	// Pattern tables, first symbol in the MSB, dash = 1, zero = no character.
	localparam logic [CHAR_W-1:0] LEN1_TAB [2] = '{7'd69, 7'd84};
	localparam logic [CHAR_W-1:0] LEN2_TAB [4] = '{7'd73, 7'd65, 7'd78, 7'd77};
	localparam logic [CHAR_W-1:0] LEN3_TAB [8] = '{
		7'd83, 7'd85, 7'd82, 7'd87, 7'd68, 7'd75, 7'd71, 7'd79
	};
	localparam logic [CHAR_W-1:0] LEN4_TAB [16] = '{
		7'd72, 7'd86, 7'd70, 7'd0, 7'd76, 7'd0, 7'd80, 7'd74,
		7'd66, 7'd88, 7'd67, 7'd89, 7'd90, 7'd81, 7'd0, 7'd0
	};
	localparam logic [CHAR_W-1:0] LEN5_TAB [32] = '{
		7'd53, 7'd52, 7'd0, 7'd51, 7'd0, 7'd0, 7'd0, 7'd50,
		7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd49,
		7'd54, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0, 7'd0,
		7'd55, 7'd0, 7'd0, 7'd0, 7'd56, 7'd0, 7'd57, 7'd48
	};

	function automatic logic [CHAR_W-1:0] decode_char(
		input logic [SYM_CNT_W-1:0] cnt,
		input logic [SYM_W-1:0]     code
	);
		logic [CHAR_W-1:0] c;
		unique case (cnt)
			3'd1:    c = LEN1_TAB[code[0]];
			3'd2:    c = LEN2_TAB[code[1:0]];
			3'd3:    c = LEN3_TAB[code[2:0]];
			3'd4:    c = LEN4_TAB[code[3:0]];
			3'd5:    c = LEN5_TAB[code[4:0]];
			default: c = '0;
		endcase
		return c;
	endfunction

endpackage

/* hw/rtl/mkd_front.sv */
`timescale 1ns / 1ps
module mkd_front #(
	parameter int TIMER_BITS = mkd_pkg::TIMER_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_fire,
	input  logic                           key_level,
	input  logic                           cfg_fire,
	input  logic [mkd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mkd_pkg::CFG_W-1:0]      cfg_data,
	output mkd_pkg::ev_t                   ev
);
	import mkd_pkg::*;

	localparam int CMP_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

	logic [CFG_W-1:0]      dot_min_q, dash_min_q, gap_len_q;
	logic                  key_was_q, gap_run_q;
	logic [TIMER_BITS-1:0] press_q, gap_q;
	logic [TIMER_BITS-1:0] press_inc, gap_inc;
	logic [CMP_W-1:0]      press_x, gap_x;
	logic                  is_dot, is_dash, gap_hit;

	assign press_inc = (press_q == '1) ? press_q : press_q + TIMER_BITS'(1);
	assign gap_inc   = (gap_q == '1) ? gap_q : gap_q + TIMER_BITS'(1);
	assign press_x   = CMP_W'(press_q);
	assign gap_x     = CMP_W'(gap_inc);
	assign is_dash   = press_x >= CMP_W'(dash_min_q);
	assign is_dot    = (press_x > CMP_W'(dot_min_q)) && !is_dash;
	assign gap_hit   = gap_x >= CMP_W'(gap_len_q);

	always_comb begin
		ev.valid = 1'b0;
		ev.kind  = EV_GAP;
		if (in_fire && !key_level) begin
			if (key_was_q) begin
				ev.valid = is_dot || is_dash;
				ev.kind  = is_dash ? EV_DASH : EV_DOT;
			end else if (gap_run_q && gap_hit) begin
				ev.valid = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dot_min_q  <= DOT_MIN_RST;
			dash_min_q <= DASH_MIN_RST;
			gap_len_q  <= GAP_LEN_RST;
		end else if (cfg_fire) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_DOT_MIN:  dot_min_q  <= cfg_data;
				CFG_DASH_MIN: dash_min_q <= cfg_data;
				CFG_GAP_LEN:  gap_len_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_was_q <= 1'b0;
			gap_run_q <= 1'b1;
			press_q   <= '0;
			gap_q     <= '0;
		end else if (in_fire) begin
			key_was_q <= key_level;
			if (key_level) begin
				press_q   <= press_inc;
				gap_run_q <= 1'b0;
			end else if (key_was_q) begin
				press_q   <= '0;
				gap_q     <= '0;
				gap_run_q <= 1'b1;
			end else if (gap_run_q) begin
				gap_q <= gap_hit ? '0 : gap_inc;
			end
		end
	end

endmodule

/* hw/rtl/mkd_evq.sv */
`timescale 1ns / 1ps
module mkd_evq (
	input  logic         clk,
	input  logic         arst_n,
	input  mkd_pkg::ev_t push,
	input  logic         pop,
	output logic         full,
	output mkd_pkg::ev_t head
);
	import mkd_pkg::*;

	ev_kind_t          mem_q [EVQ_DEPTH];
	logic [EVQ_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [EVQ_AW:0]   cnt_q;
	logic              do_pop;

	assign full       = cnt_q == (EVQ_AW + 1)'(EVQ_DEPTH);
	assign head.valid = cnt_q != '0;
	assign head.kind  = mem_q[rd_ptr_q];
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (push.valid) begin
			mem_q[wr_ptr_q] <= push.kind;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push.valid) begin
				wr_ptr_q <= wr_ptr_q + EVQ_AW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + EVQ_AW'(1);
			end
			if (push.valid && !do_pop) begin
				cnt_q <= cnt_q + (EVQ_AW + 1)'(1);
			end else if (!push.valid && do_pop) begin
				cnt_q <= cnt_q - (EVQ_AW + 1)'(1);
			end
		end
	end

endmodule

/* hw/rtl/mkd_back.sv */
`timescale 1ns / 1ps
module mkd_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  mkd_pkg::ev_t                 head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [mkd_pkg::CHAR_W-1:0]   char_code
);
	import mkd_pkg::*;

	logic [SYM_W-1:0]     code_q;
	logic [SYM_CNT_W-1:0] cnt_q;
	logic                 out_valid_q;
	logic [CHAR_W-1:0]    char_q;
	logic                 is_sym, do_decode;
	logic [CHAR_W-1:0]    dec_char;

	assign pop       = head.valid && (!out_valid_q || out_ready);
	assign is_sym    = (head.kind == EV_DOT) || (head.kind == EV_DASH);
	// A symbol on a full store forces the decode and is dropped.
	assign do_decode = !is_sym || (cnt_q >= MAX_SYMBOLS);
	assign dec_char  = decode_char(cnt_q, code_q);

	assign out_valid = out_valid_q;
	assign char_code = char_q;

	always_ff @(posedge clk) begin
		if (pop && do_decode) begin
			char_q <= dec_char;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			code_q      <= '0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				out_valid_q <= do_decode && (dec_char != '0);
				if (do_decode) begin
					code_q <= '0;
					cnt_q  <= '0;
				end else begin
					code_q <= {code_q[SYM_W-2:0], head.kind == EV_DASH};
					cnt_q  <= cnt_q + SYM_CNT_W'(1);
				end
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* hw/rtl/morse_key_decoder_top.sv */
`timescale 1ns / 1ps
// Morse key decoder. Feed one debounced key sample per millisecond tick on the
// input channel (key_level: 1 pressed, 0 released); every accepted sample counts
// as one tick. A press longer than dot_min and shorter than dash_min ticks is a
// dot, one of dash_min ticks or more is a dash, shorter presses are ignored. Up
// to five symbols are held; a sixth forces a decode and is itself dropped. After
// gap_len released ticks the held pattern is decoded and an ASCII code (A-Z,
// 0-9) is offered on char_code; patterns with no character give nothing. The
// block takes one sample every cycle while the event queue has room: the front
// keeps the timers and turns each sample into at most one event in the same
// cycle, and the back decodes one event a cycle, unless its output is stalled,
// into a registered output. A four-entry event queue sits in between, so samples
// keep flowing while a character waits for out_ready; in_ready drops only once
// four events are queued behind a stalled output.
// Registers (cfg_index): 0 dot_min (reset 40), 1 dash_min (220), 2 gap_len (400);
// writes are taken every cycle and should be made while the block is idle.
module morse_key_decoder_top #(
	parameter int TIMER_BITS = mkd_pkg::TIMER_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// sample channel
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic                          key_level,
	// character channel
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [mkd_pkg::CHAR_W-1:0]    char_code,
	// register write channel
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mkd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mkd_pkg::CFG_W-1:0]     cfg_data
);
	import mkd_pkg::*;

	ev_t  fe_ev;     // event from the front, valid for one cycle
	ev_t  q_head;    // oldest queued event
	logic q_full;
	logic be_pop;
	logic in_fire;

	// Full is registered, so in_ready never depends on out_ready.
	assign in_ready  = !q_full;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// Timers and press classification.
	mkd_front #(
		.TIMER_BITS(TIMER_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_fire  (in_fire),
		.key_level(key_level),
		.cfg_fire (cfg_valid && cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.ev       (fe_ev)
	);

	// Event queue between front and back.
	mkd_evq u_evq (
		.clk   (clk),
		.arst_n(arst_n),
		.push  (fe_ev),
		.pop   (be_pop),
		.full  (q_full),
		.head  (q_head)
	);

	// Symbol store, pattern lookup, output register.
	mkd_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (q_head),
		.pop      (be_pop),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.char_code(char_code)
	);

endmodule

/* hw/rtl/mkd_chk.sv */
`timescale 1ns / 1ps
`include "morse_key_decoder_top_macros.svh"
module mkd_chk (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [mkd_pkg::CHAR_W-1:0] char_code,
	input logic                       cfg_valid,
	input logic                       cfg_ready
);
	logic out_stall;
	logic char_is_digit, char_is_upper;

	assign out_stall     = out_valid && !out_ready;
	assign char_is_digit = (char_code >= 7'd48) && (char_code <= 7'd57);
	assign char_is_upper = (char_code >= 7'd65) && (char_code <= 7'd90);

	// A stalled character holds.
	`MKD_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(char_code), "stalled char changed")

	// Only letters and digits come out.
	`MKD_ASSERT_NOW(a_char_range, out_valid, char_is_digit || char_is_upper, "char not a letter or digit")

	// The input side only backs up behind a waiting character.
	`MKD_ASSERT_NOW(a_stall_cause, !in_ready, out_valid, "in_ready low with no char waiting")

	// Register writes never wait.
	`MKD_ASSERT_NOW(a_cfg_ready, cfg_valid, cfg_ready, "register write refused")
endmodule

bind morse_key_decoder_top mkd_chk u_mkd_chk (.*);

/* tb/morse_key_decoder_top_tb.sv */
`timescale 1ns / 1ps
module morse_key_decoder_top_tb;
	import mkd_pkg::*;

	localparam int HALF_PERIOD  = 6;
	localparam int CYCLE_LIMIT  = 1500000;
	// queue of four events plus the decode, with margin
	localparam int SETTLE_TICKS = 16;
	localparam int DRAIN_LIMIT  = 20000;
	localparam int PHASE_KEYS   = 16;
	localparam logic [TIMER_BITS_DEF-1:0] TICK_MAX = '1;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic              key_level = 1'b0;
	logic              out_valid;
	logic              out_ready = 1'b1;
	logic [CHAR_W-1:0] char_code;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	cfg_idx_t          cfg_index = CFG_DOT_MIN;
	logic [CFG_W-1:0]  cfg_data  = '0;

	// Timing registers as the predictor sees them.
	logic [CFG_W-1:0] dot_min_r  = DOT_MIN_RST;
	logic [CFG_W-1:0] dash_min_r = DASH_MIN_RST;
	logic [CFG_W-1:0] gap_len_r  = GAP_LEN_RST;

	// Keyer state mirrored by the predictor.
	logic                      key_prev  = 1'b0;
	logic [TIMER_BITS_DEF-1:0] press_cnt = '0;
	logic [TIMER_BITS_DEF-1:0] gap_cnt   = '0;
	logic                      gap_run   = 1'b1;
	logic [SYM_W-1:0]          sym_bits  = '0;
	logic [SYM_CNT_W-1:0]      sym_n     = '0;

	// Characters still owed by the block, oldest first.
	logic [CHAR_W-1:0] char_expect_q [$];

	// Morse tables by pattern length; first symbol is the MSB, dash is 1, '?' means none.
	string morse_tab [1:5] = '{
		"ET",
		"IANM",
		"SURWDKGO",
		"HVF?L?PJBXCYZQ??",
		"54?3???2???????16???????7???8?90"
	};

	bit          idle_on     = 1'b1;
	int unsigned stall_left  = 0;
	int unsigned cyc_cnt     = 0;
	int unsigned err_cnt     = 0;
	int unsigned keys_sent   = 0;
	int unsigned chars_seen  = 0;
	int unsigned cfg_writes  = 0;
	int unsigned timing_sets = 0;
	logic [CHAR_W-1:0] want_c;

	morse_key_decoder_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.key_level (key_level),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.char_code (char_code),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(HALF_PERIOD) clk = ~clk;

	// Hard stop in case the block hangs or drops a transfer.
	always @(posedge clk) begin
		cyc_cnt <= cyc_cnt + 1;
		if (cyc_cnt >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input int got, input int want);
		if (err_cnt < 50)
			$display("MISMATCH at cycle %0d: %s, got %0d, expected %0d", cyc_cnt, what, got, want);
		err_cnt++;
	endtask

	// ---------------------------------------------------------------
	// Predictor
	// ---------------------------------------------------------------

	// Look up the stored pattern and empty the store; zero when no character.
	function automatic logic [CHAR_W-1:0] decode_pattern();
		int    code;
		string row;
		byte   c;
		code = 0;
		c    = "?";
		for (int i = 0; i < sym_n; i++)
			code = (code << 1) | sym_bits[i];
		if (sym_n != 0) begin
			row = morse_tab[sym_n];
			c   = row[code];
		end
		sym_bits = '0;
		sym_n    = '0;
		return (c == "?") ? '0 : c[CHAR_W-1:0];
	endfunction

	// A full store turns the new symbol into a forced decode; the symbol is lost.
	function automatic logic [CHAR_W-1:0] store_symbol(input logic is_dash);
		if (sym_n >= MAX_SYMBOLS)
			return decode_pattern();
		sym_bits[sym_n] = is_dash;
		sym_n++;
		return '0;
	endfunction

	// One accepted key sample: update the timers and queue any character it yields.
	function automatic void predict_tick(input logic lvl);
		logic [CHAR_W-1:0] c;
		c = '0;
		if (lvl) begin
			if (press_cnt < TICK_MAX)
				press_cnt++;
			gap_run = 1'b0;
		end else if (key_prev) begin
			// release tick: classify, restart the gap timer, no gap count here
			if (press_cnt > dot_min_r && press_cnt < dash_min_r)
				c = store_symbol(1'b0);
			else if (press_cnt >= dash_min_r)
				c = store_symbol(1'b1);
			press_cnt = '0;
			gap_cnt   = '0;
			gap_run   = 1'b1;
		end else if (gap_run) begin
			if (gap_cnt < TICK_MAX)
				gap_cnt++;
			if (gap_cnt >= gap_len_r) begin
				gap_cnt = '0;
				c       = decode_pattern();
			end
		end
		key_prev = lvl;
		if (c != '0)
			char_expect_q.push_back(c);
	endfunction

	// ---------------------------------------------------------------
	// Output side: random stall bursts, and the checker
	// ---------------------------------------------------------------

	always @(posedge clk) begin
		if (idle_on && stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready  <= 1'b0;
		end else if (idle_on && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(0, 12);
			out_ready  <= 1'b0;
		end else begin
			stall_left <= 0;
			out_ready  <= 1'b1;
		end
	end

	// Signals are settled at the falling edge and hold until the next rising
	// edge, where the transfer takes place.
	always @(negedge clk) begin
		if (arst_n && out_valid === 1'b1 && out_ready) begin
			if (char_expect_q.size() == 0) begin
				report_mismatch("character with none expected", char_code, 0);
			end else begin
				want_c = char_expect_q.pop_front();
				if (char_code !== want_c)
					report_mismatch("char_code", char_code, want_c);
			end
			chars_seen++;
		end
	end

	// ---------------------------------------------------------------
	// Input side
	// ---------------------------------------------------------------

	// One key sample; returns at the rising edge of its transfer.
	task automatic send_key(input logic lvl);
		logic took;
		if (idle_on && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		in_valid  <= 1'b1;
		key_level <= lvl;
		do begin
			@(negedge clk);
			took = in_ready;
			@(posedge clk);
		end while (!took);
		predict_tick(lvl);
		keys_sent++;
	endtask

	task automatic key_press(input int hold, input int released);
		repeat (hold) send_key(1'b1);
		repeat (released) send_key(1'b0);
	endtask

	// Sender holds off until every owed character is out, then lets the
	// event queue empty of gap events that give no character.
	task automatic wait_for_chars();
		int spin;
		spin = 0;
		in_valid <= 1'b0;
		while (char_expect_q.size() != 0 && spin < DRAIN_LIMIT) begin
			@(posedge clk);
			spin++;
		end
		if (char_expect_q.size() != 0) begin
			report_mismatch("characters never delivered", 0, char_expect_q.size());
			char_expect_q.delete();
		end
		repeat (SETTLE_TICKS) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [CFG_W-1:0] val);
		logic took;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do begin
			@(negedge clk);
			took = cfg_ready;
			@(posedge clk);
		end while (!took);
		case (idx)
			CFG_DOT_MIN:  dot_min_r  = val;
			CFG_DASH_MIN: dash_min_r = val;
			CFG_GAP_LEN:  gap_len_r  = val;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
		cfg_writes++;
	endtask

	// New timing only once the block is idle.
	task automatic set_timing(input logic [CFG_W-1:0] dmin, input logic [CFG_W-1:0] dash,
		input logic [CFG_W-1:0] gap);
		wait_for_chars();
		write_reg(CFG_DOT_MIN, dmin);
		write_reg(CFG_DASH_MIN, dash);
		write_reg(CFG_GAP_LEN, gap);
		timing_sets++;
	endtask

	// Press length aimed at the current thresholds: mostly dots and dashes,
	// now and then one too short to count.
	function automatic int pick_hold();
		int k;
		k = $urandom_range(0, 9);
		if (k == 0 && dot_min_r >= 1)
			return $urandom_range(1, dot_min_r);
		if (k < 6 && dash_min_r > dot_min_r + 1)
			return $urandom_range(dot_min_r + 1, dash_min_r - 1);
		return ((dash_min_r == 0) ? 1 : dash_min_r) + $urandom_range(0, 3);
	endfunction

	// A well-formed character: symbols with short gaps, then a full gap.
	task automatic send_letter(input int n_sym);
		int gl;
		gl = (gap_len_r > 1) ? gap_len_r : 1;
		for (int s = 0; s < n_sym; s++) begin
			repeat (pick_hold()) send_key(1'b1);
			if (s < n_sym - 1)
				repeat (1 + $urandom_range(0, gl - 1)) send_key(1'b0);
		end
		repeat (1 + gl + $urandom_range(0, 3)) send_key(1'b0);
	endtask

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------

	// Reset timing: 40 too short, 41 a dot, 220 exactly a dash -> 'A'.
	task automatic test_reset_timing();
		key_press(40, 1);
		key_press(41, 1);
		key_press(220, 401);
		wait_for_chars();
	endtask

	// Short hand-made run: empty decode, E, a long T, then six dots where the
	// sixth forces out '5' and is dropped, leaving an empty store.
	task automatic test_directed();
		set_timing(16'd0, 16'd2, 16'd1);
		send_key(1'b0);
		key_press(1, 2);
		key_press(3, 2);
		repeat (6) key_press(1, 1);
		send_key(1'b0);
	endtask

	// Thresholds that touch or cross, so no press can be a dot.
	task automatic test_thresholds();
		set_timing(16'd5, 16'd6, 16'd3);
		for (int h = 1; h <= 8; h++) key_press(h, 4);
		set_timing(16'd3, 16'd3, 16'd2);
		for (int h = 1; h <= 6; h++) key_press(h, 3);
		set_timing(16'd9, 16'd1, 16'd2);
		for (int h = 1; h <= 4; h++) key_press(h, 3);
	endtask

	// Zero gap length decodes on every released tick but the release tick itself.
	task automatic test_gap_zero();
		set_timing(16'd1, 16'd3, 16'd0);
		repeat (20) key_press($urandom_range(1, 5), $urandom_range(1, 3));
	endtask

	// Register limits: all-ones thresholds swallow a press, an all-ones gap
	// never ends within a short pause.
	task automatic test_timer_limits();
		idle_on = 1'b0;
		set_timing(16'hFFFF, 16'hFFFF, 16'd1);
		key_press(40, 2);
		set_timing(16'd0, 16'hFFFF, 16'hFFFF);
		key_press(1, 20);
		idle_on = 1'b1;
	endtask

	// Random settings, mostly well-formed characters, some raw key noise.
	task automatic test_random_phases();
		int unsigned start;
		int          d;
		for (int phase = 0; phase < 8; phase++) begin
			case (phase)
				0: set_timing(16'd0, 16'd0, 16'd1);
				1: set_timing(16'd0, 16'd1, 16'd2);
				2: set_timing(16'd4, 16'd5, 16'd3);
				default: begin
					d = $urandom_range(0, 6);
					set_timing(CFG_W'(d), CFG_W'(d + $urandom_range(2, 8)),
						CFG_W'($urandom_range(2, 12)));
				end
			endcase
			start = keys_sent;
			while (keys_sent - start < PHASE_KEYS) begin
				if ($urandom_range(0, 4) == 0)
					repeat ($urandom_range(1, 12)) send_key(1'($urandom_range(0, 1)));
				else
					send_letter($urandom_range(1, 6));
				if ($urandom_range(0, 19) == 0)
					wait_for_chars();
			end
		end
	endtask

	// Back to back on both sides, no idling at all.
	task automatic test_steady();
		int unsigned start;
		set_timing(16'd2, 16'd5, 16'd4);
		idle_on = 1'b0;
		start = keys_sent;
		while (keys_sent - start < PHASE_KEYS)
			send_letter($urandom_range(1, 6));
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_timing();
		test_directed();
		test_thresholds();
		test_gap_zero();
		test_timer_limits();
		test_random_phases();
		test_steady();

		wait_for_chars();
		$display("Checked %0d characters decoded from %0d key samples.", chars_seen, keys_sent);
		$display("Timing changed %0d times (%0d register writes), limits included.",
			timing_sets, cfg_writes);
		if (err_cnt == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
